/* rtl/sparse_row_term_coalescer_top_assert.svh */
// Assertion macros shared by the sparse row term coalescer modules.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef SPARSE_ROW_TERM_COALESCER_TOP_ASSERT_SVH
`define SPARSE_ROW_TERM_COALESCER_TOP_ASSERT_SVH

`ifndef SYNTH
`define SRTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define SRTC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define SRTC_ASSERT(lbl, prop, msg)
`define SRTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/srtc_pkg.sv */
// Package for the sparse row term coalescer: field widths, defaults,
// function codes and the controller/datapath command and status structs.
// No dependencies.
package srtc_pkg;

	localparam int unsigned MAX_ROW_TERMS_DEF  = 32;
	localparam int unsigned VAR_INDEX_BITS_DEF = 20;

	localparam int unsigned INDEX_W  = 20;
	localparam int unsigned VAR_IN_W = 21;
	localparam int unsigned COEFF_W  = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned VCOUNT_W = 21;

	localparam logic FUNC_TERM  = 1'b0;
	localparam logic FUNC_CLOSE = 1'b1;

	typedef struct packed {
		logic take_term;
		logic take_close;
		logic merge;
		logic advance;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} ctl_stat_t;

endpackage

/* rtl/sparse_row_term_coalescer_top.sv */
// Top level of the sparse row term coalescer.
// Instantiates srtc_ctrl and srtc_dpath; depends on srtc_pkg.
//
// Terms and close beats enter on the item channel (item_valid/item_ready)
// with func, var_index, coeff and rhs. A term with a new index, or an
// optimization term, is taken without a stall; a term whose index is already
// in the row passes through the merge state, since the stored coefficient is
// read from the row memory and written back summed. A new-index term that
// finds the buffer full is dropped and flags overflow for the rest of the row.
// A close beat starts the drain: the first result beat is valid in the
// cycle after the close is accepted, and one entry follows per cycle while
// result_ready is high, limited by the single read port of the row memory.
// An empty row yields a single beat with entry_valid low. item_ready stays
// low from the close until the beat with last high is taken, and while a
// repeated index is merged. When the receiver stalls, the result beat holds.
// Reset clears the row, the row and entry counters and var_count; the row
// buffers need no clearing pass.
module sparse_row_term_coalescer_top #(
	parameter int unsigned MAX_ROW_TERMS  = srtc_pkg::MAX_ROW_TERMS_DEF,
	parameter int unsigned VAR_INDEX_BITS = srtc_pkg::VAR_INDEX_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 func,
	input  logic signed [srtc_pkg::VAR_IN_W-1:0] var_index,
	input  logic signed [srtc_pkg::COEFF_W-1:0]  coeff,
	input  logic signed [srtc_pkg::COEFF_W-1:0]  rhs,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic        [srtc_pkg::INDEX_W-1:0]  entry_index,
	output logic signed [srtc_pkg::COEFF_W-1:0]  entry_coeff,
	output logic                                 entry_valid,
	output logic        [srtc_pkg::CNT_W-1:0]    row_number,
	output logic        [srtc_pkg::CNT_W-1:0]    row_start,
	output logic        [srtc_pkg::SIZE_W-1:0]   row_size,
	output logic signed [srtc_pkg::COEFF_W-1:0]  row_rhs,
	output logic                                 row_has_opt,
	output logic signed [srtc_pkg::COEFF_W-1:0]  row_opt_coeff,
	output logic        [srtc_pkg::VCOUNT_W-1:0] var_count,
	output logic                                 overflow,
	output logic                                 last
);
	import srtc_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	srtc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.func         (func),
		.result_ready (result_ready),
		.stat         (stat),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	srtc_dpath #(
		.MAX_ROW_TERMS  (MAX_ROW_TERMS),
		.VAR_INDEX_BITS (VAR_INDEX_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.var_index     (var_index),
		.coeff         (coeff),
		.rhs           (rhs),
		.entry_index   (entry_index),
		.entry_coeff   (entry_coeff),
		.entry_valid   (entry_valid),
		.row_number    (row_number),
		.row_start     (row_start),
		.row_size      (row_size),
		.row_rhs       (row_rhs),
		.row_has_opt   (row_has_opt),
		.row_opt_coeff (row_opt_coeff),
		.var_count     (var_count),
		.overflow      (overflow),
		.last          (last)
	);

endmodule

/* rtl/srtc_ctrl.sv */
// Controller state machine of the sparse row term coalescer.
// Depends on srtc_pkg and sparse_row_term_coalescer_top_assert.svh.
`include "sparse_row_term_coalescer_top_assert.svh"
module srtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                func,
	input  logic                result_ready,
	input  srtc_pkg::ctl_stat_t stat,
	output logic                item_ready,
	output logic                result_valid,
	output srtc_pkg::ctl_cmd_t  cmd
);
	import srtc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MERGE = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = (state_q == S_DRAIN);
	assign take         = item_valid && item_ready;

	always_comb begin
		cmd.take_term  = take && (func == FUNC_TERM);
		cmd.take_close = take && (func == FUNC_CLOSE);
		cmd.merge      = (state_q == S_MERGE);
		cmd.advance    = result_valid && result_ready && !stat.last;
		cmd.finish     = result_valid && result_ready && stat.last;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take_close) begin
					state_d = S_DRAIN;
				end else if (cmd.take_term && stat.hit) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				state_d = S_IDLE;
			end
			S_DRAIN: begin
				if (cmd.finish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SRTC_ASSERT(a_ready_excl_valid, !(item_ready && result_valid), "ready with result pending")
	`SRTC_ASSERT(a_merge_one_cycle, (state_q == S_MERGE) |=> (state_q == S_IDLE), "merge overran")
	`SRTC_ASSERT(a_drain_ends_on_last, $fell(result_valid) |-> $past(result_ready && stat.last), "drain cut short")

endmodule

/* rtl/srtc_dpath.sv */
// Datapath of the sparse row term coalescer: row buffers, parallel index
// compare, coefficient memory and row bookkeeping. Depends on srtc_pkg and
// sparse_row_term_coalescer_top_assert.svh.
`include "sparse_row_term_coalescer_top_assert.svh"
module srtc_dpath #(
	parameter int unsigned MAX_ROW_TERMS  = srtc_pkg::MAX_ROW_TERMS_DEF,
	parameter int unsigned VAR_INDEX_BITS = srtc_pkg::VAR_INDEX_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  srtc_pkg::ctl_cmd_t                       cmd,
	output srtc_pkg::ctl_stat_t                      stat,
	input  logic signed [srtc_pkg::VAR_IN_W-1:0]     var_index,
	input  logic signed [srtc_pkg::COEFF_W-1:0]      coeff,
	input  logic signed [srtc_pkg::COEFF_W-1:0]      rhs,
	output logic        [srtc_pkg::INDEX_W-1:0]      entry_index,
	output logic signed [srtc_pkg::COEFF_W-1:0]      entry_coeff,
	output logic                                     entry_valid,
	output logic        [srtc_pkg::CNT_W-1:0]        row_number,
	output logic        [srtc_pkg::CNT_W-1:0]        row_start,
	output logic        [srtc_pkg::SIZE_W-1:0]       row_size,
	output logic signed [srtc_pkg::COEFF_W-1:0]      row_rhs,
	output logic                                     row_has_opt,
	output logic signed [srtc_pkg::COEFF_W-1:0]      row_opt_coeff,
	output logic        [srtc_pkg::VCOUNT_W-1:0]     var_count,
	output logic                                     overflow,
	output logic                                     last
);
	import srtc_pkg::*;

	localparam int unsigned FILL_W = $clog2(MAX_ROW_TERMS + 1);
	localparam int unsigned AW     = (MAX_ROW_TERMS > 1) ? $clog2(MAX_ROW_TERMS) : 1;
	localparam int unsigned KEEP_W = (VAR_INDEX_BITS < INDEX_W) ? VAR_INDEX_BITS : INDEX_W;

	logic [KEEP_W-1:0]  idx_buf [MAX_ROW_TERMS];
	logic [COEFF_W-1:0] coeff_mem [MAX_ROW_TERMS];

	logic [FILL_W-1:0]   fill_q;
	logic                opt_seen_q;
	logic [COEFF_W-1:0]  opt_val_q;
	logic                drop_q;
	logic [CNT_W-1:0]    rows_q;
	logic [CNT_W-1:0]    emitted_q;
	logic [VCOUNT_W-1:0] maxv_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       hit_addr_q;
	logic [COEFF_W-1:0]  term_coeff_q;
	logic [COEFF_W-1:0]  rd_q;
	logic [KEEP_W-1:0]   out_idx_q;
	logic [COEFF_W-1:0]  rhs_q;

	logic [KEEP_W-1:0]        idx;
	logic                     is_opt;
	logic [MAX_ROW_TERMS-1:0] match;
	logic [AW-1:0]            hit_addr;
	logic                     full;
	logic                     append;
	logic                     drop;
	logic [VCOUNT_W-1:0]      cand;
	logic [AW-1:0]            ptr_next;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [COEFF_W-1:0]       wr_data;
	logic [CNT_W:0]           emitted_sum;
	logic [CNT_W:0]           rows_sum;

	assign idx    = var_index[KEEP_W-1:0];
	assign is_opt = var_index[VAR_IN_W-1];

	always_comb begin
		hit_addr = '0;
		for (int k = 0; k < MAX_ROW_TERMS; k++) begin
			match[k] = (FILL_W'(k) < fill_q) && (idx_buf[k] == idx);
			if (match[k]) begin
				hit_addr = hit_addr | AW'(k);
			end
		end
	end

	assign stat.hit  = !is_opt && (|match);
	assign stat.last = (fill_q == '0) || ((FILL_W'(ptr_q) + FILL_W'(1)) == fill_q);

	assign full     = (fill_q == FILL_W'(MAX_ROW_TERMS));
	assign append   = cmd.take_term && !is_opt && !stat.hit && !full;
	assign drop     = cmd.take_term && !is_opt && !stat.hit && full;
	assign cand     = VCOUNT_W'(idx) + VCOUNT_W'(1);
	assign ptr_next = AW'(ptr_q + AW'(1));

	assign rd_en   = cmd.take_term || cmd.take_close || cmd.advance;
	assign rd_addr = cmd.take_term ? hit_addr : (cmd.take_close ? AW'(0) : ptr_next);
	assign wr_en   = cmd.merge || append;
	assign wr_addr = cmd.merge ? hit_addr_q : fill_q[AW-1:0];
	assign wr_data = cmd.merge ? (rd_q + term_coeff_q) : coeff;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coeff_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= coeff_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (append) begin
			idx_buf[fill_q[AW-1:0]] <= idx;
		end
		if (cmd.take_term) begin
			hit_addr_q   <= hit_addr;
			term_coeff_q <= coeff;
		end
		if (cmd.take_close) begin
			rhs_q     <= rhs;
			out_idx_q <= idx_buf[0];
		end else if (cmd.advance) begin
			out_idx_q <= idx_buf[ptr_next];
		end
	end

	assign emitted_sum = {1'b0, emitted_q} + (CNT_W + 1)'(fill_q);
	assign rows_sum    = {1'b0, rows_q} + (CNT_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			opt_seen_q <= 1'b0;
			opt_val_q  <= '0;
			drop_q     <= 1'b0;
			rows_q     <= '0;
			emitted_q  <= '0;
			maxv_q     <= '0;
			ptr_q      <= '0;
		end else begin
			if (cmd.take_term && is_opt) begin
				opt_seen_q <= 1'b1;
				opt_val_q  <= coeff;
			end
			if (append) begin
				fill_q <= fill_q + FILL_W'(1);
				if (cand > maxv_q) begin
					maxv_q <= cand;
				end
			end
			if (drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.take_close) begin
				ptr_q <= '0;
			end else if (cmd.advance) begin
				ptr_q <= ptr_next;
			end
			if (cmd.finish) begin
				emitted_q  <= emitted_sum[CNT_W] ? '1 : emitted_sum[CNT_W-1:0];
				rows_q     <= rows_sum[CNT_W] ? '1 : rows_sum[CNT_W-1:0];
				fill_q     <= '0;
				opt_seen_q <= 1'b0;
				opt_val_q  <= '0;
				drop_q     <= 1'b0;
			end
		end
	end

	assign entry_valid   = (fill_q != '0);
	assign entry_index   = entry_valid ? INDEX_W'(out_idx_q) : '0;
	assign entry_coeff   = entry_valid ? rd_q : '0;
	assign row_number    = rows_q;
	assign row_start     = emitted_q;
	assign row_size      = SIZE_W'(fill_q);
	assign row_rhs       = rhs_q;
	assign row_has_opt   = opt_seen_q;
	assign row_opt_coeff = opt_val_q;
	assign var_count     = maxv_q;
	assign overflow      = drop_q;
	assign last          = stat.last;

	`SRTC_ASSERT(a_fill_bound, fill_q <= FILL_W'(MAX_ROW_TERMS), "row fill beyond buffer")
	`SRTC_ASSERT(a_finish_clears, cmd.finish |=> (fill_q == '0) && !drop_q && !opt_seen_q, "row not cleared")
	`SRTC_ASSERT(a_drop_sticky, (drop_q && !cmd.finish) |=> drop_q, "overflow lost mid row")

endmodule

/* tb/tb.sv */
// Self-checking testbench for sparse_row_term_coalescer_top: drives term and close
// beats, predicts each coalesced row in a model of its own and checks every result beat.
// Depends on srtc_pkg and the RTL of the sparse row term coalescer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srtc_pkg::*;

	localparam int unsigned ROW_DEPTH   = MAX_ROW_TERMS_DEF;
	localparam int unsigned STALL_LIMIT = 5000;

	typedef struct packed {
		logic [INDEX_W-1:0]  entry_index;
		logic [COEFF_W-1:0]  entry_coeff;
		logic                entry_valid;
		logic [CNT_W-1:0]    row_number;
		logic [CNT_W-1:0]    row_start;
		logic [SIZE_W-1:0]   row_size;
		logic [COEFF_W-1:0]  row_rhs;
		logic                row_has_opt;
		logic [COEFF_W-1:0]  row_opt_coeff;
		logic [VCOUNT_W-1:0] var_count;
		logic                overflow;
		logic                last;
	} row_entry_t;

	logic                        clk;
	logic                        arst_n       = 1'b0;
	logic                        item_valid   = 1'b0;
	logic                        func         = FUNC_TERM;
	logic signed [VAR_IN_W-1:0]  var_index    = '0;
	logic signed [COEFF_W-1:0]   coeff        = '0;
	logic signed [COEFF_W-1:0]   rhs          = '0;
	logic                        result_ready = 1'b0;
	logic                        item_ready;
	logic                        result_valid;
	logic        [INDEX_W-1:0]   entry_index;
	logic signed [COEFF_W-1:0]   entry_coeff;
	logic                        entry_valid;
	logic        [CNT_W-1:0]     row_number;
	logic        [CNT_W-1:0]     row_start;
	logic        [SIZE_W-1:0]    row_size;
	logic signed [COEFF_W-1:0]   row_rhs;
	logic                        row_has_opt;
	logic signed [COEFF_W-1:0]   row_opt_coeff;
	logic        [VCOUNT_W-1:0]  var_count;
	logic                        overflow;
	logic                        last;

	logic [INDEX_W-1:0]  row_index_model [ROW_DEPTH];
	logic [COEFF_W-1:0]  row_coeff_model [ROW_DEPTH];
	int unsigned         row_fill_model     = 0;
	logic                opt_seen_model     = 1'b0;
	logic [COEFF_W-1:0]  opt_value_model    = '0;
	logic                drop_model         = 1'b0;
	logic [CNT_W-1:0]    rows_closed_model  = '0;
	logic [CNT_W-1:0]    entries_done_model = '0;
	logic [VCOUNT_W-1:0] var_count_model    = '0;
	row_entry_t          pending_entries[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent    = 0;
	int error_count   = 0;
	int stall_cycles  = 0;

	sparse_row_term_coalescer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.func          (func),
		.var_index     (var_index),
		.coeff         (coeff),
		.rhs           (rhs),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.entry_index   (entry_index),
		.entry_coeff   (entry_coeff),
		.entry_valid   (entry_valid),
		.row_number    (row_number),
		.row_start     (row_start),
		.row_size      (row_size),
		.row_rhs       (row_rhs),
		.row_has_opt   (row_has_opt),
		.row_opt_coeff (row_opt_coeff),
		.var_count     (var_count),
		.overflow      (overflow),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	task automatic coalesce_beat(input logic f, input logic [VAR_IN_W-1:0] vi,
			input logic [COEFF_W-1:0] c, input logic [COEFF_W-1:0] r);
		logic [INDEX_W-1:0] idx;
		logic               hit;
		int unsigned        n;
		row_entry_t         e;
		idx = vi[INDEX_W-1:0];
		hit = 1'b0;
		if (f == FUNC_TERM) begin
			if (vi[VAR_IN_W-1]) begin
				opt_seen_model  = 1'b1;
				opt_value_model = c;
			end else begin
				for (int k = 0; k < row_fill_model; k++) begin
					if (!hit && row_index_model[k] == idx) begin
						row_coeff_model[k] = row_coeff_model[k] + c;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (row_fill_model >= ROW_DEPTH) begin
						drop_model = 1'b1;
					end else begin
						row_index_model[row_fill_model] = idx;
						row_coeff_model[row_fill_model] = c;
						row_fill_model++;
						if ({1'b0, idx} + 1'b1 > var_count_model)
							var_count_model = {1'b0, idx} + 1'b1;
					end
				end
			end
		end else begin
			n = (row_fill_model == 0) ? 1 : row_fill_model;
			for (int k = 0; k < n; k++) begin
				e.entry_valid   = (k < row_fill_model);
				e.entry_index   = e.entry_valid ? row_index_model[k] : '0;
				e.entry_coeff   = e.entry_valid ? row_coeff_model[k] : '0;
				e.row_number    = rows_closed_model;
				e.row_start     = entries_done_model;
				e.row_size      = SIZE_W'(row_fill_model);
				e.row_rhs       = r;
				e.row_has_opt   = opt_seen_model;
				e.row_opt_coeff = opt_seen_model ? opt_value_model : '0;
				e.var_count     = var_count_model;
				e.overflow      = drop_model;
				e.last          = (k == n - 1);
				pending_entries.push_back(e);
			end
			entries_done_model = sat_add(entries_done_model, row_fill_model);
			rows_closed_model  = sat_add(rows_closed_model, 1);
			row_fill_model     = 0;
			opt_seen_model     = 1'b0;
			opt_value_model    = '0;
			drop_model         = 1'b0;
		end
	endtask

	task automatic send_beat(input logic f, input logic [VAR_IN_W-1:0] vi,
			input logic [COEFF_W-1:0] c, input logic [COEFF_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= f;
		var_index  <= vi;
		coeff      <= c;
		rhs        <= r;
		do @(posedge clk); while (!item_ready);
		coalesce_beat(f, vi, c, r);
		items_sent++;
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_entries.size() != 0);
	endtask

	function automatic logic [COEFF_W-1:0] random_coeff();
		case ($urandom_range(9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VAR_IN_W-1:0] random_index();
		int          pick;
		logic [31:0] r;
		pick = $urandom_range(99);
		r    = $urandom;
		if (pick < 3)
			return '1;
		else if (pick < 10)
			return {1'b1, r[INDEX_W-1:0]};
		else if (pick < 70)
			return VAR_IN_W'($urandom_range(0, 15));
		else if (pick < 90)
			return VAR_IN_W'($urandom_range(0, 255));
		else
			return {1'b0, r[INDEX_W-1:0]};
	endfunction

	task automatic test_empty_row();
		send_beat(FUNC_CLOSE, '1, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(FUNC_CLOSE, '0, 32'h8000_0000, 32'h7fff_ffff);
	endtask

	task automatic test_merge_wraparound();
		send_beat(FUNC_TERM, 21'd0, 32'h7fff_ffff, $urandom);
		send_beat(FUNC_TERM, 21'd5, 32'hffff_ffff, $urandom);
		send_beat(FUNC_TERM, 21'd0, 32'h0000_0001, $urandom);
		send_beat(FUNC_TERM, 21'd5, 32'h8000_0000, $urandom);
		send_beat(FUNC_TERM, '1, 32'h0000_0007, $urandom);
		send_beat(FUNC_TERM, '1, 32'h8000_0000, $urandom);
		send_beat(FUNC_CLOSE, VAR_IN_W'($urandom), $urandom, 32'h7fff_ffff);
	endtask

	task automatic test_opt_only();
		send_beat(FUNC_TERM, 21'h1f_0000, 32'h0000_0005, $urandom);
		send_beat(FUNC_TERM, '1, 32'h0000_0000, $urandom);
		send_beat(FUNC_CLOSE, VAR_IN_W'($urandom), $urandom, 32'h0000_0000);
	endtask

	task automatic test_buffer_full();
		for (int k = 0; k < ROW_DEPTH + 2; k++)
			send_beat(FUNC_TERM, VAR_IN_W'(1000 + k), random_coeff(), $urandom);
		send_beat(FUNC_TERM, 21'd1000, random_coeff(), $urandom);
		send_beat(FUNC_TERM, VAR_IN_W'(1000 + ROW_DEPTH + 1), random_coeff(), $urandom);
		send_beat(FUNC_TERM, '1, random_coeff(), $urandom);
		send_beat(FUNC_CLOSE, VAR_IN_W'($urandom), $urandom, random_coeff());
	endtask

	task automatic test_random_rows(input int s_pct, input int r_pct, input int n_items);
		int stop_at;
		int len;
		int pick;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at       = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80)
				len = $urandom_range(0, 8);
			else if (pick < 96)
				len = $urandom_range(9, ROW_DEPTH);
			else
				len = $urandom_range(ROW_DEPTH + 1, ROW_DEPTH + 6);
			for (int k = 0; k < len; k++)
				send_beat(FUNC_TERM, random_index(), random_coeff(), $urandom);
			send_beat(FUNC_CLOSE, VAR_IN_W'($urandom), $urandom, random_coeff());
		end
	endtask

	task automatic test_index_extremes();
		send_beat(FUNC_TERM, 21'h0f_ffff, 32'h7fff_ffff, $urandom);
		send_beat(FUNC_TERM, 21'h0f_ffff, 32'h0000_0001, $urandom);
		send_beat(FUNC_TERM, 21'h10_0000, 32'h0000_0000, $urandom);
		send_beat(FUNC_TERM, 21'd0, 32'h8000_0000, $urandom);
		send_beat(FUNC_CLOSE, '1, '1, 32'h0000_0000);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		row_entry_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_entries.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result beat with no expected entry", $time);
			end else begin
				e = pending_entries.pop_front();
				check_field("entry_index", e.entry_index, entry_index);
				check_field("entry_coeff", e.entry_coeff, entry_coeff);
				check_field("entry_valid", e.entry_valid, entry_valid);
				check_field("row_number", e.row_number, row_number);
				check_field("row_start", e.row_start, row_start);
				check_field("row_size", e.row_size, row_size);
				check_field("row_rhs", e.row_rhs, row_rhs);
				check_field("row_has_opt", e.row_has_opt, row_has_opt);
				check_field("row_opt_coeff", e.row_opt_coeff, row_opt_coeff);
				check_field("var_count", e.var_count, var_count);
				check_field("overflow", e.overflow, overflow);
				check_field("last", e.last, last);
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 31;
		recv_idle_pct = 70;
		test_empty_row();
		test_merge_wraparound();
		test_opt_only();
		test_buffer_full();
		test_random_rows(31, 70, 50);
		wait_for_drain();
		test_random_rows(70, 31, 50);
		test_random_rows(0, 0, 50);
		test_index_extremes();
		item_valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
